// ===== src/frac_pkg.sv =====
// ----------------------------------------------------------------------------
// frac_pkg: shared types for the fraction arithmetic core
// Function codes, datapath commands, datapath status and controller states.
// ----------------------------------------------------------------------------
package frac_pkg;

    localparam int DEFAULT_OPERAND_WIDTH = 16;

    // operation selector carried with every input word
    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    // datapath micro-operations issued by the controller
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_MUL_A,
        DP_MUL_B,
        DP_MUL_C,
        DP_MUL_D,
        DP_GCD_INIT,
        DP_REM_START,
        DP_REM_TAKE,
        DP_QN_START,
        DP_QN_TAKE,
        DP_QD_TAKE,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic err;
        logic b_zero;
        logic div_done;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_CHECK,
        ST_GCD_TEST,
        ST_REM_WAIT,
        ST_QN_WAIT,
        ST_QD_WAIT,
        ST_DONE
    } ctrl_state_t;

endpackage

// ===== src/frac_if.sv =====
// ----------------------------------------------------------------------------
// frac_if: word channels of the fraction arithmetic core
// Input channel with two fractions and a selector, output channel with the
// reduced fraction and the error flag.
// ----------------------------------------------------------------------------
interface frac_in_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic        [1:0]   func;
    logic signed [W-1:0] first_numerator;
    logic signed [W-1:0] first_denominator;
    logic signed [W-1:0] second_numerator;
    logic signed [W-1:0] second_denominator;

    modport source (
        output valid, func, first_numerator, first_denominator,
               second_numerator, second_denominator,
        input  ready
    );

    modport sink (
        input  valid, func, first_numerator, first_denominator,
               second_numerator, second_denominator,
        output ready
    );
endinterface

interface frac_out_if #(
    parameter int W = 16
);
    localparam int RW = 2 * W + 1;

    logic                 valid;
    logic                 ready;
    logic signed [RW-1:0] result_numerator;
    logic signed [RW-1:0] result_denominator;
    logic                 undefined_error;

    modport source (
        output valid, result_numerator, result_denominator, undefined_error,
        input  ready
    );

    modport sink (
        input  valid, result_numerator, result_denominator, undefined_error,
        output ready
    );
endinterface

// ===== src/frac_div.sv =====
// ----------------------------------------------------------------------------
// frac_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, with the
// truncating quotient and remainder signs applied at the output.
// ----------------------------------------------------------------------------
module frac_div #(
    parameter int RW = 33
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [RW-1:0] dividend,
    input  logic signed [RW-1:0] divisor,
    output logic                 done,
    output logic signed [RW-1:0] quotient,
    output logic signed [RW-1:0] remainder
);
    localparam int CW = $clog2(RW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rem_reg, quo_reg, div_reg;
    logic          neg_q_reg, neg_r_reg;

    logic [RW-1:0] mag_dividend, mag_divisor;
    logic [RW:0]   shifted;
    logic [RW+1:0] diff;
    logic          last;

    // operand magnitudes
    assign mag_dividend = dividend[RW-1] ? -dividend : dividend;
    assign mag_divisor  = divisor[RW-1]  ? -divisor  : divisor;

    // trial subtract for one quotient bit
    assign shifted = {rem_reg, quo_reg[RW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign last    = (cnt_reg == CW'(RW - 1));

    // control sequencing
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift and subtract datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= mag_dividend;
            div_reg   <= mag_divisor;
            neg_q_reg <= dividend[RW-1] ^ divisor[RW-1];
            neg_r_reg <= dividend[RW-1];
        end
        else if (busy_reg)
        begin
            if (!diff[RW+1])
            begin
                rem_reg <= diff[RW-1:0];
                quo_reg <= {quo_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[RW-1:0];
                quo_reg <= {quo_reg[RW-2:0], 1'b0};
            end
        end
    end

    // sign fix-up
    assign done      = done_reg;
    assign quotient  = neg_q_reg ? -quo_reg : quo_reg;
    assign remainder = neg_r_reg ? -rem_reg : rem_reg;

endmodule

// ===== src/frac_datapath.sv =====
// ----------------------------------------------------------------------------
// frac_datapath: operand registers, multiplier and gcd datapath
// Forms the unreduced fraction with one shared multiplier, runs Euclid's
// remainder steps on the divider and holds the reduced result.
// ----------------------------------------------------------------------------
module frac_datapath #(
    parameter int W = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  frac_pkg::dp_cmd_t      cmd,
    output frac_pkg::dp_status_t   status,
    input  logic [1:0]             func,
    input  logic signed [W-1:0]    first_numerator,
    input  logic signed [W-1:0]    first_denominator,
    input  logic signed [W-1:0]    second_numerator,
    input  logic signed [W-1:0]    second_denominator,
    output logic signed [2*W:0]    result_numerator,
    output logic signed [2*W:0]    result_denominator,
    output logic                   undefined_error
);
    import frac_pkg::*;

    localparam int RW = 2 * W + 1;
    localparam int PW = 2 * W;

    func_t                func_reg;
    logic signed [W-1:0]  n1_reg, d1_reg, n2_reg, d2_reg;
    logic signed [PW-1:0] mul_reg;
    logic signed [RW-1:0] num_reg, den_reg, a_reg, b_reg;
    logic signed [RW-1:0] qn_reg, qd_reg;
    logic                 err_reg;
    logic signed [RW-1:0] res_num_reg, res_den_reg;
    logic                 res_err_reg;

    logic signed [W-1:0]  mul_x, mul_y;
    logic signed [PW-1:0] product;
    logic signed [RW-1:0] mul_ext;
    logic                 div_start;
    logic signed [RW-1:0] div_dividend, div_divisor;
    logic                 div_done;
    logic signed [RW-1:0] div_quo, div_rem;

    // multiplier operand selection per phase
    always_comb
    begin
        mul_x = n1_reg;
        mul_y = d2_reg;
        case (cmd.op)
            DP_MUL_A:
            begin
                mul_x = n1_reg;
                mul_y = (func_reg == FUNC_MUL) ? n2_reg : d2_reg;
            end
            DP_MUL_B:
            begin
                mul_x = n2_reg;
                mul_y = d1_reg;
            end
            DP_MUL_C:
            begin
                mul_x = d1_reg;
                mul_y = (func_reg == FUNC_DIV) ? n2_reg : d2_reg;
            end
            default:
            begin
                mul_x = n1_reg;
                mul_y = d2_reg;
            end
        endcase
    end

    assign product = mul_x * mul_y;
    assign mul_ext = {mul_reg[PW-1], mul_reg};

    // divider operand selection
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = a_reg;
        div_divisor  = b_reg;
        case (cmd.op)
            DP_REM_START:
            begin
                div_start = 1'b1;
            end
            DP_QN_START:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                div_divisor  = a_reg;
            end
            DP_QN_TAKE:
            begin
                div_start    = 1'b1;
                div_dividend = den_reg;
                div_divisor  = a_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    frac_div #(
        .RW (RW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                func_reg <= func_t'(func);
                n1_reg   <= first_numerator;
                d1_reg   <= first_denominator;
                n2_reg   <= second_numerator;
                d2_reg   <= second_denominator;
            end
            DP_MUL_A:
            begin
                mul_reg <= product;
            end
            DP_MUL_B:
            begin
                num_reg <= mul_ext;
                mul_reg <= product;
            end
            DP_MUL_C:
            begin
                if (func_reg == FUNC_ADD)
                begin
                    num_reg <= num_reg + mul_ext;
                end
                else if (func_reg == FUNC_SUB)
                begin
                    num_reg <= num_reg - mul_ext;
                end
                mul_reg <= product;
            end
            DP_MUL_D:
            begin
                den_reg <= mul_ext;
            end
            DP_GCD_INIT:
            begin
                a_reg   <= num_reg;
                b_reg   <= den_reg;
                err_reg <= (num_reg == '0) && (den_reg == '0);
            end
            DP_REM_TAKE:
            begin
                a_reg <= b_reg;
                b_reg <= div_rem;
            end
            DP_QN_TAKE:
            begin
                qn_reg <= div_quo;
            end
            DP_QD_TAKE:
            begin
                qd_reg <= div_quo;
            end
            DP_PUBLISH:
            begin
                res_num_reg <= err_reg ? '0 : qn_reg;
                res_den_reg <= err_reg ? '0 : qd_reg;
                res_err_reg <= err_reg;
            end
            default:
            begin
            end
        endcase
    end

    // status back to the controller
    assign status.err      = err_reg;
    assign status.b_zero   = (b_reg == '0);
    assign status.div_done = div_done;

    assign result_numerator   = res_num_reg;
    assign result_denominator = res_den_reg;
    assign undefined_error    = res_err_reg;

endmodule

// ===== src/frac_ctrl.sv =====
// ----------------------------------------------------------------------------
// frac_ctrl: sequencing state machine
// Steps the datapath through multiply, gcd and reduction phases and owns
// the input ready and output valid handshake.
// ----------------------------------------------------------------------------
module frac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output frac_pkg::dp_cmd_t    cmd,
    input  frac_pkg::dp_status_t status
);
    import frac_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    dp_op_t      op;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        op             = DP_NONE;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = DP_LOAD;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                op         = DP_MUL_A;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                op         = DP_MUL_B;
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                op         = DP_MUL_C;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                op         = DP_MUL_D;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                op         = DP_GCD_INIT;
                state_next = ST_GCD_TEST;
            end
            ST_GCD_TEST:
            begin
                if (status.err)
                begin
                    state_next = ST_DONE;
                end
                else if (status.b_zero)
                begin
                    op         = DP_QN_START;
                    state_next = ST_QN_WAIT;
                end
                else
                begin
                    op         = DP_REM_START;
                    state_next = ST_REM_WAIT;
                end
            end
            ST_REM_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = DP_REM_TAKE;
                    state_next = ST_GCD_TEST;
                end
            end
            ST_QN_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = DP_QN_TAKE;
                    state_next = ST_QD_WAIT;
                end
            end
            ST_QD_WAIT:
            begin
                if (status.div_done)
                begin
                    op         = DP_QD_TAKE;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // output register free or emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    op             = DP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cmd.op    = op;
    assign out_valid = out_valid_reg;

endmodule

// ===== src/fraction_arith_reduce_core.sv =====
// ----------------------------------------------------------------------------
// fraction_arith_reduce_core: fraction add, subtract, multiply and divide
// Top level joining the sequencing controller and the gcd datapath.
// ----------------------------------------------------------------------------
// One word at a time: an accepted word forms the unreduced fraction in the
// states ST_MUL_A to ST_MUL_D on a single shared multiplier, then runs
// Euclid's algorithm with a one-bit-per-cycle divider of 2*W+1 bits, then
// divides numerator and denominator by the gcd on the same divider. The next
// word is taken as soon as the result is parked in the output register, even
// while it waits to be taken. When both unreduced terms are zero,
// undefined_error is set and the result is zero.
module fraction_arith_reduce_core #(
    parameter int OPERAND_WIDTH = frac_pkg::DEFAULT_OPERAND_WIDTH
) (
    input logic      clk,
    input logic      rst_n,
    frac_in_if.sink  in_ch,
    frac_out_if.source out_ch
);
    import frac_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing controller
    frac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // arithmetic datapath
    frac_datapath #(
        .W (OPERAND_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .func               (in_ch.func),
        .first_numerator    (in_ch.first_numerator),
        .first_denominator  (in_ch.first_denominator),
        .second_numerator   (in_ch.second_numerator),
        .second_denominator (in_ch.second_denominator),
        .result_numerator   (out_ch.result_numerator),
        .result_denominator (out_ch.result_denominator),
        .undefined_error    (out_ch.undefined_error)
    );

endmodule

// ===== src/frac_checker.sv =====
// ----------------------------------------------------------------------------
// frac_checker: port-level checks for the fraction arithmetic core
// Watches the word channels of the top level, attached by a bind.
// ----------------------------------------------------------------------------
module frac_checker #(
    parameter int W = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [2*W:0]  result_numerator,
    input logic signed [2*W:0]  result_denominator,
    input logic                 undefined_error
);

    // a pending result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_numerator)
            && $stable(result_denominator) && $stable(undefined_error))
        else $error("stalled result changed");

    // one word in flight: input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while one is in flight");

    // error results carry zeros, other results never 0/0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && undefined_error |->
            result_numerator == '0 && result_denominator == '0)
        else $error("error result with nonzero payload");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !undefined_error |->
            result_numerator != '0 || result_denominator != '0)
        else $error("zero over zero without error flag");

endmodule

bind fraction_arith_reduce_core frac_checker #(
    .W (OPERAND_WIDTH)
) u_frac_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .result_numerator   (out_ch.result_numerator),
    .result_denominator (out_ch.result_denominator),
    .undefined_error    (out_ch.undefined_error)
);

// ===== bench/tb_fraction_arith_reduce_core.sv =====
// ----------------------------------------------------------------------------
// tb_fraction_arith_reduce_core: self-checking bench for the fraction core
// Drives fraction pairs with every function code through the input channel,
// predicts the reduced fraction and error flag of each accepted word, and
// compares every result word in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_fraction_arith_reduce_core;

    import frac_pkg::*;

    localparam int OW = DEFAULT_OPERAND_WIDTH;
    localparam int RW = 2 * OW + 1;
    localparam int RANDOM_WORDS = 1850;
    localparam int SETTLE_CYCLES = 2000;
    localparam logic signed [OW-1:0] OP_MIN = {1'b1, {(OW-1){1'b0}}};
    localparam logic signed [OW-1:0] OP_MAX = {1'b0, {(OW-1){1'b1}}};

    // one input word, plus a flag that holds it back until all results are in
    typedef struct {
        func_t               func;
        logic signed [OW-1:0] n1;
        logic signed [OW-1:0] d1;
        logic signed [OW-1:0] n2;
        logic signed [OW-1:0] d2;
        logic                 drain;
    } frac_word_t;

    typedef struct {
        logic signed [RW-1:0] num;
        logic signed [RW-1:0] den;
        logic                 undef;
    } frac_result_t;

    logic clk = 1'b0;
    logic rst_n;

    frac_in_if  #(.W(OW)) in_ch ();
    frac_out_if #(.W(OW)) out_ch ();

    fraction_arith_reduce_core #(
        .OPERAND_WIDTH(OW)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    frac_word_t   word_queue[$];
    frac_result_t reduced_expect[$];
    frac_word_t   cur_word;
    int           words_sent;
    int           words_got;
    int           mismatches;
    int           send_gap;
    int           stall_left;
    logic         calm;
    logic [11:0]  calm_timer;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reduced fraction of one word: cross-multiply (straight for FUNC_MUL), then divide by signed gcd
    function automatic frac_result_t reduce_fraction(frac_word_t w);
        longint       n1;
        longint       d1;
        longint       n2;
        longint       d2;
        longint       num;
        longint       den;
        longint       a;
        longint       b;
        longint       t;
        frac_result_t r;
        n1 = w.n1;
        d1 = w.d1;
        n2 = w.n2;
        d2 = w.d2;
        case (w.func)
            FUNC_ADD:
            begin
                num = n1 * d2 + n2 * d1;
                den = d1 * d2;
            end
            FUNC_SUB:
            begin
                num = n1 * d2 - n2 * d1;
                den = d1 * d2;
            end
            FUNC_MUL:
            begin
                num = n1 * n2;
                den = d1 * d2;
            end
            default:
            begin
                num = n1 * d2;
                den = d1 * n2;
            end
        endcase
        if (num == 0 && den == 0)
        begin
            r.num = '0;
            r.den = '0;
            r.undef = 1'b1;
        end
        else
        begin
            a = num;
            b = den;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            r.num = RW'(num / a);
            r.den = RW'(den / a);
            r.undef = 1'b0;
        end
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(logic quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 6);
        else if (r < 97)
            return $urandom_range(7, 80);
        else
            return $urandom_range(81, 1500);
    endfunction

    // operand: small, full range, extreme, or a product with shared factors
    function automatic logic signed [OW-1:0] pick_operand();
        int unsigned          r;
        logic signed [OW-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 25)
            v = OW'(int'($urandom_range(0, 24)) - 12);
        else if (r < 55)
            v = OW'($urandom());
        else if (r < 70)
        begin
            case ($urandom_range(0, 6))
                0: v = OP_MIN;
                1: v = OW'(OP_MIN + 1);
                2: v = OP_MAX;
                3: v = OW'(OP_MAX - 1);
                4: v = 1;
                5: v = -1;
                default: v = 0;
            endcase
        end
        else
        begin
            v = OW'($urandom_range(1, 181) * $urandom_range(0, 181));
            if ($urandom_range(0, 1))
                v = -v;
        end
        return v;
    endfunction

    task automatic add_word(func_t f, logic signed [OW-1:0] n1, logic signed [OW-1:0] d1,
                            logic signed [OW-1:0] n2, logic signed [OW-1:0] d2,
                            logic drain);
        frac_word_t w;
        w.func = f;
        w.n1 = n1;
        w.d1 = d1;
        w.n2 = n2;
        w.d2 = d2;
        w.drain = drain;
        word_queue.push_back(w);
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("mismatch %0d at %0t: %s", mismatches, $realtime, msg);
    endtask

    // quiet stretches with no idling on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calm_timer <= '0;
            calm <= 1'b0;
        end
        else
        begin
            calm_timer <= calm_timer + 1'b1;
            if (calm_timer == '0)
                calm <= ($urandom_range(0, 3) == 0);
        end
    end

    // driver: feeds queued words, predicts on accept, holds drain words back
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.func <= '0;
            in_ch.first_numerator <= '0;
            in_ch.first_denominator <= '0;
            in_ch.second_numerator <= '0;
            in_ch.second_denominator <= '0;
            send_gap = 0;
            words_sent = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                reduced_expect.push_back(reduce_fraction(cur_word));
                words_sent++;
                send_gap = pick_gap(calm);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (word_queue.size() != 0 &&
                         !(word_queue[0].drain && words_sent != words_got))
                begin
                    cur_word = word_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.func <= cur_word.func;
                    in_ch.first_numerator <= cur_word.n1;
                    in_ch.first_denominator <= cur_word.d1;
                    in_ch.second_numerator <= cur_word.n2;
                    in_ch.second_denominator <= cur_word.d2;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        frac_result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            words_got <= 0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                words_got <= words_got + 1;
                if (reduced_expect.size() == 0)
                    report_mismatch("result word with no word outstanding");
                else
                begin
                    want = reduced_expect.pop_front();
                    if (out_ch.result_numerator !== want.num)
                        report_mismatch($sformatf("numerator got %0d want %0d",
                                        out_ch.result_numerator, want.num));
                    if (out_ch.result_denominator !== want.den)
                        report_mismatch($sformatf("denominator got %0d want %0d",
                                        out_ch.result_denominator, want.den));
                    if (out_ch.undefined_error !== want.undef)
                        report_mismatch($sformatf("error flag got %b want %b",
                                        out_ch.undefined_error, want.undef));
                end
                stall_left = pick_gap(calm);
            end
            else if (out_ch.ready && !calm && $urandom_range(0, 63) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left != 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        frac_word_t w;
        int unsigned r;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.first_numerator = '0;
        in_ch.first_denominator = '0;
        in_ch.second_numerator = '0;
        in_ch.second_denominator = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;

        // directed: each function, extremes, both-zero and zero denominator
        add_word(FUNC_ADD, 1, 2, 1, 3, 1'b0);
        add_word(FUNC_SUB, 1, 2, 1, 2, 1'b0);
        add_word(FUNC_MUL, 3, 4, -2, 9, 1'b0);
        add_word(FUNC_DIV, 3, 4, 5, 7, 1'b0);
        add_word(FUNC_MUL, 0, 0, 5, 7, 1'b0);
        add_word(FUNC_ADD, 4, 0, -3, 0, 1'b0);
        add_word(FUNC_DIV, 0, 3, 0, 5, 1'b0);
        add_word(FUNC_DIV, 3, 4, 0, 5, 1'b0);
        add_word(FUNC_DIV, -3, 4, 0, 5, 1'b0);
        add_word(FUNC_MUL, 7, 0, -5, 3, 1'b0);
        add_word(FUNC_SUB, -6, 0, 2, 0, 1'b0);
        add_word(FUNC_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1'b0);
        add_word(FUNC_ADD, OP_MAX, OP_MIN, OP_MIN, OP_MAX, 1'b0);
        add_word(FUNC_SUB, OP_MIN, OP_MAX, OP_MAX, OP_MIN, 1'b0);
        add_word(FUNC_DIV, OP_MIN, 1, 1, OP_MIN, 1'b0);
        add_word(FUNC_MUL, OP_MAX, 1, OP_MAX, 1, 1'b0);
        add_word(FUNC_ADD, OP_MIN, -1, OP_MIN, -1, 1'b0);
        add_word(FUNC_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1'b0);
        add_word(FUNC_SUB, OP_MAX, OW'(OP_MIN + 1), OP_MIN, OP_MAX, 1'b0);
        add_word(FUNC_MUL, -1, -1, -1, -1, 1'b0);
        add_word(FUNC_DIV, OP_MAX, OW'(OP_MAX - 1), OW'(OP_MIN + 1), OP_MIN, 1'b0);
        add_word(FUNC_SUB, 5, -7, 3, 11, 1'b0);
        add_word(FUNC_ADD, -1, OP_MIN, 0, 1, 1'b0);

        // random words, some held until the core has drained
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            w.func = func_t'($urandom_range(0, 3));
            w.n1 = pick_operand();
            w.d1 = pick_operand();
            w.n2 = pick_operand();
            w.d2 = pick_operand();
            w.drain = (i % 300 == 0);
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                // both unreduced terms zero for every function
                w.n1 = '0;
                w.d1 = '0;
            end
            word_queue.push_back(w);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (word_queue.size() != 0 || in_ch.valid)
            @(negedge clk);
        while (words_got != words_sent)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (reduced_expect.size() != 0)
            report_mismatch($sformatf("%0d predictions never matched",
                            reduced_expect.size()));

        if (mismatches == 0)
            $display("PASS fraction_arith_reduce_core");
        else
            $display("FAIL fraction_arith_reduce_core");
        $finish;
    end

    // watchdog
    initial
    begin
        #500_000_000;
        $display("FAIL fraction_arith_reduce_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/frac_pkg.sv
src/frac_if.sv
src/frac_div.sv
src/frac_datapath.sv
src/frac_ctrl.sv
src/fraction_arith_reduce_core.sv
src/frac_checker.sv
bench/tb_fraction_arith_reduce_core.sv
